FILE: design/usb_power_role_boost_controller_top_assert.svh
// Assertion macros for the power role controller.
`ifndef USB_POWER_ROLE_BOOST_CONTROLLER_TOP_ASSERT_SVH
`define USB_POWER_ROLE_BOOST_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UPRBC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UPRBC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/uprbc_pkg.sv
// Shared types and constants of the power role and boost controller.
`timescale 1ns / 1ps
`default_nettype none

package uprbc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DRAW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRAW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_GAP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAISE_INT  = 3'd4;

    localparam logic [15:0] IDLE_DRAW_RST  = 16'd700;
    localparam logic [15:0] MAX_DRAW_RST   = 16'd8000;
    localparam logic [15:0] BOOST_GAP_RST  = 16'd500;
    localparam logic [15:0] OVER_DELAY_RST = 16'd500;
    localparam logic [15:0] RAISE_INT_RST  = 16'd100;

    // USB role codes as seen on the result port
    localparam logic [1:0] USB_ROLE_CLIENT = 2'd0;
    localparam logic [1:0] USB_ROLE_BOOST  = 2'd1;
    localparam logic [1:0] USB_ROLE_PASS   = 2'd2;

    // Port status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_PASS   = 2'd1;
    localparam logic [1:0] ST_CHARGE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    // Pin drive codes
    localparam logic [1:0] NEG_CLIENT = 2'd2;
    localparam logic [1:0] NEG_BOOST  = 2'd1;
    localparam logic [1:0] NEG_PASS   = 2'd3;
    localparam logic [1:0] CC_CLIENT  = 2'd0;
    localparam logic [1:0] CC_BOOST   = 2'd2;
    localparam logic [1:0] CC_PASS    = 2'd1;

    localparam logic [3:0] LEVEL_MAX   = 4'hF;
    localparam logic [6:0] PCT_FULL    = 7'd100;

    // floor(x / 100) == (x * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit x
    localparam int         PROD_W       = 31;
    localparam int         PWR_W        = 25;
    localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int         DIV100_SHIFT = 37;

    typedef struct packed {
        logic        vbus;
        logic        chg;
        logic [6:0]  pct;
        logic [15:0] cur;
        logic [15:0] cur_avg;
        logic [15:0] volt;
        logic        button;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [15:0] idle_draw;
        logic [15:0] max_draw;
        logic [15:0] boost_gap;
        logic [15:0] over_delay;
        logic [15:0] raise_int;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       role;
        logic [1:0]       status;
        logic [3:0]       level;
        logic [PWR_W-1:0] power;
        logic             otg;
        logic             alt_dis;
        logic [1:0]       neg;
        logic [1:0]       cc;
        logic             pulse;
        logic             fault;
    } res_t;

endpackage

`default_nettype wire

FILE: design/usb_power_role_boost_controller_top.sv
// Top level of the USB power role and boost controller.
`timescale 1ns / 1ps
`default_nettype none

// USB power role and boost controller.
// Input channel (in_valid / in_stall): one transaction per tick with VBUS and
//   charge port presence, battery readings, the role button event and now_ms.
// Output channel (out_valid / out_stall): one result transaction per input
//   transaction, in order: role, port status, boost level, output power,
//   pin drives, the alternate charger reset pulse and the overdraw fault.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
//   indexes past the last register are dropped. Write only while idle.
// An accepted input transaction passes through the input register, the
//   product stage, the divide stage and the result register on its way
//   out. Throughput: one per cycle while out_stall stays low.
// Role state advances as an item leaves the divide stage into the result
//   register, so each item sees the state left by the one before it.
// Reset: role client, port status none, level 0, both deadlines cleared,
//   configuration back to its defaults, pipeline empty.
// A stalled result holds in the output register; stages upstream keep
//   filling until every stage is full, then in_stall rises.
module usb_power_role_boost_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                vbus_present,
    input  logic                                charge_port_present,
    input  logic [6:0]                          battery_percent,
    input  logic signed [15:0]                  battery_current,
    input  logic signed [15:0]                  battery_current_avg,
    input  logic [15:0]                         battery_voltage,
    input  logic                                button_event,
    input  logic [31:0]                         now_ms,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          usb_role,
    output logic [1:0]                          port_status,
    output logic [3:0]                          boost_level,
    output logic [24:0]                         boost_output_mw,
    output logic                                otg_enable,
    output logic                                alt_charger_disable,
    output logic [1:0]                          negotiator_mode,
    output logic [1:0]                          cc_source,
    output logic                                alt_reset_pulse,
    output logic                                overdraw_fault,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uprbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);

    logic                        in_valid_reg;
    uprbc_pkg::item_t            in_item_reg;
    logic                        out_valid_reg;
    uprbc_pkg::res_t             res_reg;

    uprbc_pkg::item_t            in_item;
    uprbc_pkg::cfg_t             cfg;
    uprbc_pkg::item_t            pw_item;
    uprbc_pkg::res_t             res_next;
    logic [uprbc_pkg::PWR_W-1:0] pw_fast;
    logic [uprbc_pkg::PWR_W-1:0] pw_avg;
    logic                        pw_up_ready;
    logic                        pw_dn_valid;
    logic                        in_reg_ready;
    logic                        out_ready;
    logic                        step;

    // Config writes complete in the cycle they are offered
    assign cfg_ready = 1'b1;

    uprbc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb
    begin
        in_item.vbus    = vbus_present;
        in_item.chg     = charge_port_present;
        in_item.pct     = battery_percent;
        in_item.cur     = battery_current;
        in_item.cur_avg = battery_current_avg;
        in_item.volt    = battery_voltage;
        in_item.button  = button_event;
        in_item.now     = now_ms;
    end

    // Input register: take a new transaction whenever it is empty or moving on
    assign in_reg_ready = !in_valid_reg || pw_up_ready;
    assign in_stall     = !in_reg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_reg_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_reg_ready)
            in_item_reg <= in_item;
    end

    uprbc_power u_power (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid_reg),
        .up_item  (in_item_reg),
        .up_ready (pw_up_ready),
        .dn_valid (pw_dn_valid),
        .dn_item  (pw_item),
        .dn_fast  (pw_fast),
        .dn_avg   (pw_avg),
        .dn_ready (out_ready)
    );

    // Result register: advance the role state as an item moves into it
    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = pw_dn_valid && out_ready;

    uprbc_role u_role (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (pw_item),
        .fast    (pw_fast),
        .avg_out (pw_avg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= pw_dn_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign out_valid           = out_valid_reg;
    assign usb_role            = res_reg.role;
    assign port_status         = res_reg.status;
    assign boost_level         = res_reg.level;
    assign boost_output_mw     = res_reg.power;
    assign otg_enable          = res_reg.otg;
    assign alt_charger_disable = res_reg.alt_dis;
    assign negotiator_mode     = res_reg.neg;
    assign cc_source           = res_reg.cc;
    assign alt_reset_pulse     = res_reg.pulse;
    assign overdraw_fault      = res_reg.fault;

endmodule

`default_nettype wire

FILE: design/uprbc_cfg.sv
// Configuration register file of the power role controller.
`timescale 1ns / 1ps
`default_nettype none

module uprbc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [uprbc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]                   wr_data,
    output uprbc_pkg::cfg_t               cfg
);

    uprbc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_draw  <= uprbc_pkg::IDLE_DRAW_RST;
            cfg_reg.max_draw   <= uprbc_pkg::MAX_DRAW_RST;
            cfg_reg.boost_gap  <= uprbc_pkg::BOOST_GAP_RST;
            cfg_reg.over_delay <= uprbc_pkg::OVER_DELAY_RST;
            cfg_reg.raise_int  <= uprbc_pkg::RAISE_INT_RST;
        end
        else if (wr_en)
        begin
            // drop writes to unknown indexes
            unique case (wr_index)
                uprbc_pkg::CFG_IDLE_DRAW:  cfg_reg.idle_draw  <= wr_data;
                uprbc_pkg::CFG_MAX_DRAW:   cfg_reg.max_draw   <= wr_data;
                uprbc_pkg::CFG_BOOST_GAP:  cfg_reg.boost_gap  <= wr_data;
                uprbc_pkg::CFG_OVER_DELAY: cfg_reg.over_delay <= wr_data;
                uprbc_pkg::CFG_RAISE_INT:  cfg_reg.raise_int  <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/uprbc_power.sv
// Two-stage power pipeline: current times voltage, then divide by 100.
`timescale 1ns / 1ps
`default_nettype none

module uprbc_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    input  uprbc_pkg::item_t               up_item,
    output logic                           up_ready,
    output logic                           dn_valid,
    output uprbc_pkg::item_t               dn_item,
    output logic [uprbc_pkg::PWR_W-1:0]    dn_fast,
    output logic [uprbc_pkg::PWR_W-1:0]    dn_avg,
    input  logic                           dn_ready
);

    localparam int QW = 2 * uprbc_pkg::PROD_W;

    logic                            s1_valid_reg;
    uprbc_pkg::item_t                s1_item_reg;
    logic [uprbc_pkg::PROD_W-1:0]    cur_prod_reg;
    logic [uprbc_pkg::PROD_W-1:0]    avg_prod_reg;
    logic                            s2_valid_reg;
    uprbc_pkg::item_t                s2_item_reg;
    logic [uprbc_pkg::PWR_W-1:0]     fast_reg;
    logic [uprbc_pkg::PWR_W-1:0]     avg_reg;

    logic        s1_ready;
    logic        s2_ready;
    logic [16:0] cur_abs;
    logic [16:0] avg_abs;
    logic [32:0] cur_prod_full;
    logic [32:0] avg_prod_full;
    logic [QW-1:0] cur_q_full;
    logic [QW-1:0] avg_q_full;

    function automatic logic [16:0] abs16(input logic [15:0] raw);
        if (raw[15])
            return 17'h10000 - {1'b0, raw};
        return {1'b0, raw};
    endfunction

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    assign cur_abs       = abs16(up_item.cur);
    assign avg_abs       = abs16(up_item.cur_avg);
    assign cur_prod_full = {16'b0, cur_abs} * {17'b0, up_item.volt};
    assign avg_prod_full = {16'b0, avg_abs} * {17'b0, up_item.volt};

    // products stay below 2^31: 32768 * 65535
    assign cur_q_full = QW'(cur_prod_reg) * QW'(uprbc_pkg::DIV100_MAGIC);
    assign avg_q_full = QW'(avg_prod_reg) * QW'(uprbc_pkg::DIV100_MAGIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= up_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && s1_ready)
        begin
            s1_item_reg  <= up_item;
            cur_prod_reg <= cur_prod_full[uprbc_pkg::PROD_W-1:0];
            avg_prod_reg <= avg_prod_full[uprbc_pkg::PROD_W-1:0];
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg <= s1_item_reg;
            fast_reg    <= cur_q_full[uprbc_pkg::DIV100_SHIFT +: uprbc_pkg::PWR_W];
            avg_reg     <= avg_q_full[uprbc_pkg::DIV100_SHIFT +: uprbc_pkg::PWR_W];
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_item  = s2_item_reg;
    assign dn_fast  = fast_reg;
    assign dn_avg   = avg_reg;

endmodule

`default_nettype wire

FILE: design/uprbc_role.sv
// Role state machine, boost regulation and pin drive state.
`timescale 1ns / 1ps
`default_nettype none

module uprbc_role (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  uprbc_pkg::item_t            item,
    input  logic [uprbc_pkg::PWR_W-1:0] fast,
    input  logic [uprbc_pkg::PWR_W-1:0] avg_out,
    input  uprbc_pkg::cfg_t             cfg,
    output uprbc_pkg::res_t             res
);

`include "usb_power_role_boost_controller_top_assert.svh"

    typedef enum logic [2:0] {
        ROLE_CLIENT = 3'b001,
        ROLE_BOOST  = 3'b010,
        ROLE_PASS   = 3'b100
    } role_t;

    typedef struct packed {
        role_t                       role;
        logic [1:0]                  status;
        logic [3:0]                  level;
        logic [31:0]                 over_dl;
        logic [31:0]                 raise_dl;
        logic                        otg;
        logic                        alt_dis;
        logic [1:0]                  neg;
        logic [1:0]                  cc;
        logic [uprbc_pkg::PWR_W-1:0] power;
    } st_t;

    st_t state_reg;
    st_t state_next;
    logic pulse;
    logic fault;

    function automatic st_t enter_role(input st_t s, input role_t r);
        st_t t;
        t       = s;
        t.role  = r;
        t.power = '0;
        unique case (r)
            ROLE_CLIENT:
            begin
                t.status = uprbc_pkg::ST_NONE;
                t.neg    = uprbc_pkg::NEG_CLIENT;
                t.cc     = uprbc_pkg::CC_CLIENT;
            end
            ROLE_BOOST:
            begin
                t.status  = uprbc_pkg::ST_PASS;
                t.alt_dis = 1'b1;
                t.otg     = 1'b1;
                t.neg     = uprbc_pkg::NEG_BOOST;
                t.cc      = uprbc_pkg::CC_BOOST;
            end
            ROLE_PASS:
            begin
                t.status = uprbc_pkg::ST_PASS;
                t.otg    = 1'b0;
                t.neg    = uprbc_pkg::NEG_PASS;
                t.cc     = uprbc_pkg::CC_PASS;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [1:0] role_code(input role_t r);
        logic [1:0] c;
        unique case (r)
            ROLE_CLIENT: c = uprbc_pkg::USB_ROLE_CLIENT;
            ROLE_BOOST:  c = uprbc_pkg::USB_ROLE_BOOST;
            ROLE_PASS:   c = uprbc_pkg::USB_ROLE_PASS;
            default:     c = uprbc_pkg::USB_ROLE_CLIENT;
        endcase
        return c;
    endfunction

    always_comb
    begin
        st_t                         s;
        logic                        btn;
        logic                        over;
        logic                        under;
        logic [uprbc_pkg::PWR_W-1:0] idle_w;
        logic [uprbc_pkg::PWR_W-1:0] max_w;
        logic [uprbc_pkg::PWR_W:0]   fast_gap;

        s      = state_reg;
        btn    = item.button;
        pulse  = 1'b0;
        fault  = 1'b0;
        idle_w = uprbc_pkg::PWR_W'(cfg.idle_draw);
        max_w  = uprbc_pkg::PWR_W'(cfg.max_draw);
        over   = fast > max_w;
        under  = fast < idle_w;
        fast_gap = {1'b0, fast} + (uprbc_pkg::PWR_W + 1)'(cfg.boost_gap);

        // client pass
        if (s.role == ROLE_CLIENT)
        begin
            if (item.vbus)
            begin
                if (s.status == uprbc_pkg::ST_NONE)
                    s.status = uprbc_pkg::ST_CHARGE;
                if (s.status == uprbc_pkg::ST_CHARGE && !item.chg)
                begin
                    if (item.pct == uprbc_pkg::PCT_FULL)
                        s.status = uprbc_pkg::ST_DONE;
                    else if (item.cur[15])
                        pulse = 1'b1;
                end
                s.otg     = !item.chg;
                s.alt_dis = item.chg;
            end
            else
            begin
                s.status  = uprbc_pkg::ST_NONE;
                s.otg     = 1'b0;
                s.alt_dis = 1'b1;
            end
            if (btn)
            begin
                btn = 1'b0;
                s   = enter_role(s, item.chg ? ROLE_PASS : ROLE_BOOST);
            end
        end

        // boost pass: regulate level against the fast power reading
        if (s.role == ROLE_BOOST)
        begin
            s.power = (avg_out < idle_w) ? '0 : avg_out - idle_w;
            if (over || under)
            begin
                if (s.level != 4'd0)
                    s.level = s.level - 4'd1;
                else if (over)
                begin
                    if (s.over_dl == 32'd0)
                        s.over_dl = item.now + {16'b0, cfg.over_delay};
                    if (s.over_dl < item.now)
                    begin
                        fault = 1'b1;
                        s     = enter_role(s, ROLE_CLIENT);
                    end
                end
            end
            else if (fast_gap < (uprbc_pkg::PWR_W + 1)'(cfg.max_draw) && fast > idle_w)
            begin
                s.over_dl = 32'd0;
                if (s.raise_dl < item.now)
                begin
                    if (s.level < uprbc_pkg::LEVEL_MAX)
                        s.level = s.level + 4'd1;
                    s.raise_dl = item.now + {16'b0, cfg.raise_int};
                end
            end
            if (btn)
            begin
                btn = 1'b0;
                s   = enter_role(s, ROLE_CLIENT);
            end
            if (item.chg)
                s = enter_role(s, ROLE_PASS);
        end

        // pass-through pass
        if (s.role == ROLE_PASS)
        begin
            if (btn)
            begin
                btn = 1'b0;
                s   = enter_role(s, ROLE_CLIENT);
            end
            if (!item.chg)
                s = enter_role(s, ROLE_BOOST);
        end

        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.role     <= ROLE_CLIENT;
            state_reg.status   <= uprbc_pkg::ST_NONE;
            state_reg.level    <= 4'd0;
            state_reg.over_dl  <= 32'd0;
            state_reg.raise_dl <= 32'd0;
            state_reg.otg      <= 1'b0;
            state_reg.alt_dis  <= 1'b0;
            state_reg.neg      <= uprbc_pkg::NEG_CLIENT;
            state_reg.cc       <= uprbc_pkg::CC_CLIENT;
            state_reg.power    <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        res.role    = role_code(state_next.role);
        res.status  = state_next.status;
        res.level   = state_next.level;
        res.power   = state_next.power;
        res.otg     = state_next.otg;
        res.alt_dis = state_next.alt_dis;
        res.neg     = state_next.neg;
        res.cc      = state_next.cc;
        res.pulse   = pulse;
        res.fault   = fault;
    end

    `UPRBC_CHECK(a_boost_pins, state_reg.role == ROLE_BOOST,
        state_reg.otg && state_reg.neg == uprbc_pkg::NEG_BOOST
        && state_reg.cc == uprbc_pkg::CC_BOOST, "boost role with wrong pin drives")
    `UPRBC_CHECK(a_pass_pins, state_reg.role == ROLE_PASS,
        !state_reg.otg && state_reg.neg == uprbc_pkg::NEG_PASS
        && state_reg.cc == uprbc_pkg::CC_PASS, "pass role with wrong pin drives")
    `UPRBC_CHECK(a_client_pins, state_reg.role == ROLE_CLIENT,
        state_reg.neg == uprbc_pkg::NEG_CLIENT && state_reg.cc == uprbc_pkg::CC_CLIENT
        && state_reg.power == '0, "client role with wrong drives or power")
    `UPRBC_CHECK_NEXT(a_level_hold, !step, $stable(state_reg.level),
        "boost level moved without a transaction")

endmodule

`default_nettype wire

FILE: test/usb_power_role_boost_controller_checker.sv
// Result checker for the USB power role and boost controller: predicts and compares each result.
`timescale 1ns / 1ps

module usb_power_role_boost_controller_checker
    import uprbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  item_t                tick,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  res_t                 report,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   reports_pending,
    output int                   failures,
    output int                   shutoffs
);

    localparam int REPORT_LIMIT = 10;

    cfg_t             limits;
    logic [1:0]       role_q;
    logic [1:0]       status_q;
    logic [3:0]       level_q;
    logic [31:0]      overdraw_due;
    logic [31:0]      raise_due;
    logic             otg_q;
    logic             alt_dis_q;
    logic [1:0]       neg_q;
    logic [1:0]       cc_q;
    logic [PWR_W-1:0] power_q;

    res_t expected_reports[$];
    res_t predicted;
    res_t due;
    int   fail_total;
    int   fault_total;
    int   reports_seen;

    assign failures = fail_total;
    assign shutoffs = fault_total;

    function automatic logic [16:0] magnitude(input logic [15:0] raw);
        return raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
    endfunction

    function automatic void take_role(input logic [1:0] next_role);
        role_q  = next_role;
        power_q = '0;
        case (next_role)
            USB_ROLE_CLIENT:
            begin
                status_q = ST_NONE;
                neg_q    = NEG_CLIENT;
                cc_q     = CC_CLIENT;
            end
            USB_ROLE_BOOST:
            begin
                status_q  = ST_PASS;
                alt_dis_q = 1'b1;
                otg_q     = 1'b1;
                neg_q     = NEG_BOOST;
                cc_q      = CC_BOOST;
            end
            default:
            begin
                status_q = ST_PASS;
                otg_q    = 1'b0;
                neg_q    = NEG_PASS;
                cc_q     = CC_PASS;
            end
        endcase
    endfunction

    // Client, boost and pass stages in order; one tick may run several.
    function automatic res_t evaluate_tick(input item_t it);
        res_t            r;
        logic            button;
        logic            pulse;
        logic            fault;
        longint unsigned cur_mag;
        longint unsigned avg_mag;
        longint unsigned avg_mw;
        longint unsigned fast_mw;
        longint unsigned idle_mw;
        longint unsigned max_mw;
        button  = it.button;
        pulse   = 1'b0;
        fault   = 1'b0;
        cur_mag = magnitude(it.cur);
        avg_mag = magnitude(it.cur_avg);
        if (role_q == USB_ROLE_CLIENT)
        begin
            if (it.vbus)
            begin
                if (status_q == ST_NONE)
                    status_q = ST_CHARGE;
                if (status_q == ST_CHARGE && !it.chg)
                begin
                    if (it.pct == PCT_FULL)
                        status_q = ST_DONE;
                    else if (it.cur[15])
                        pulse = 1'b1;
                end
                otg_q     = !it.chg;
                alt_dis_q = it.chg;
            end
            else
            begin
                status_q  = ST_NONE;
                otg_q     = 1'b0;
                alt_dis_q = 1'b1;
            end
            if (button)
            begin
                button = 1'b0;
                take_role(it.chg ? USB_ROLE_PASS : USB_ROLE_BOOST);
            end
        end
        if (role_q == USB_ROLE_BOOST)
        begin
            avg_mw  = avg_mag * it.volt / 100;
            fast_mw = cur_mag * it.volt / 100;
            idle_mw = limits.idle_draw;
            max_mw  = limits.max_draw;
            power_q = (avg_mw < idle_mw) ? '0 : PWR_W'(avg_mw - idle_mw);
            if (fast_mw > max_mw || fast_mw < idle_mw)
            begin
                if (level_q != '0)
                    level_q = level_q - 1'b1;
                else if (fast_mw > max_mw)
                begin
                    // zero means unarmed, even when now plus the delay wraps there
                    if (overdraw_due == '0)
                        overdraw_due = it.now + limits.over_delay;
                    if (overdraw_due < it.now)
                    begin
                        fault = 1'b1;
                        take_role(USB_ROLE_CLIENT);
                    end
                end
            end
            else if (fast_mw + limits.boost_gap < max_mw && fast_mw > idle_mw)
            begin
                overdraw_due = '0;
                if (raise_due < it.now)
                begin
                    if (level_q < LEVEL_MAX)
                        level_q = level_q + 1'b1;
                    raise_due = it.now + limits.raise_int;
                end
            end
            if (button)
            begin
                button = 1'b0;
                take_role(USB_ROLE_CLIENT);
            end
            if (it.chg)
                take_role(USB_ROLE_PASS);
        end
        if (role_q == USB_ROLE_PASS)
        begin
            if (button)
            begin
                button = 1'b0;
                take_role(USB_ROLE_CLIENT);
            end
            if (!it.chg)
                take_role(USB_ROLE_BOOST);
        end
        r.role    = role_q;
        r.status  = status_q;
        r.level   = level_q;
        r.power   = power_q;
        r.otg     = otg_q;
        r.alt_dis = alt_dis_q;
        r.neg     = neg_q;
        r.cc      = cc_q;
        r.pulse   = pulse;
        r.fault   = fault;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits       = '{IDLE_DRAW_RST, MAX_DRAW_RST, BOOST_GAP_RST,
                             OVER_DELAY_RST, RAISE_INT_RST};
            role_q       = USB_ROLE_CLIENT;
            status_q     = ST_NONE;
            level_q      = '0;
            overdraw_due = '0;
            raise_due    = '0;
            otg_q        = 1'b0;
            alt_dis_q    = 1'b0;
            neg_q        = NEG_CLIENT;
            cc_q         = CC_CLIENT;
            power_q      = '0;
            expected_reports.delete();
            fail_total   = 0;
            fault_total  = 0;
            reports_seen = 0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDLE_DRAW:  limits.idle_draw  = cfg_data;
                    CFG_MAX_DRAW:   limits.max_draw   = cfg_data;
                    CFG_BOOST_GAP:  limits.boost_gap  = cfg_data;
                    CFG_OVER_DELAY: limits.over_delay = cfg_data;
                    CFG_RAISE_INT:  limits.raise_int  = cfg_data;
                    default:        ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected: %h",
                                 reports_seen, report);
                end
                else
                begin
                    due = expected_reports.pop_front();
                    if (report !== due)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            $display("result %0d mismatch, expected/actual:", reports_seen);
                            $display("  role %0d/%0d status %0d/%0d level %0d/%0d power %0d/%0d",
                                     due.role, report.role, due.status, report.status,
                                     due.level, report.level, due.power, report.power);
                            $display("  otg %b/%b alt %b/%b neg %0d/%0d cc %0d/%0d pulse %b/%b fault %b/%b",
                                     due.otg, report.otg, due.alt_dis, report.alt_dis,
                                     due.neg, report.neg, due.cc, report.cc,
                                     due.pulse, report.pulse, due.fault, report.fault);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted = evaluate_tick(tick);
                if (predicted.fault)
                    fault_total++;
                expected_reports.push_back(predicted);
            end
            reports_pending <= expected_reports.size();
        end
    end

endmodule

FILE: test/usb_power_role_boost_controller_top_tb.sv
// Testbench top for the USB power role and boost controller: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module usb_power_role_boost_controller_top_tb;

    import uprbc_pkg::*;

    // Generous cycle budget: roughly 1100 ticks, with random idle cycles
    // on the send side plus random stalls on the result side.
    localparam int RUN_LIMIT    = 200000;
    // Wait a little longer at the end, once the pipeline has drained.
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEM_W       = $bits(item_t);

    // Directed operating points at the nominal cell voltage: with the reset
    // limits, light draw is under the idle bound, the window current sits
    // between idle and max minus gap, heavy draw at full voltage is far over.
    localparam int NOMINAL_VOLT = 4000;
    localparam int FULL_VOLT    = 65535;
    localparam int LIGHT_CUR    = 5;
    localparam int WINDOW_CUR   = 100;
    localparam int HEAVY_CUR    = 32767;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    item_t                tick;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    res_t                 report;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    logic [1:0]  usb_role;
    logic [1:0]  port_status;
    logic [3:0]  boost_level;
    logic [24:0] boost_output_mw;
    logic        otg_enable;
    logic        alt_charger_disable;
    logic [1:0]  negotiator_mode;
    logic [1:0]  cc_source;
    logic        alt_reset_pulse;
    logic        overdraw_fault;

    int reports_pending;
    int failures;
    int shutoffs;

    // Mirror of the register settings, used only to aim the random draw bands.
    cfg_t        knobs;
    logic [31:0] clock_ms;
    logic        calm = 1'b0;
    int          ticks_sent;
    int          settings_used;

    usb_power_role_boost_controller_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .vbus_present        (tick.vbus),
        .charge_port_present (tick.chg),
        .battery_percent     (tick.pct),
        .battery_current     (tick.cur),
        .battery_current_avg (tick.cur_avg),
        .battery_voltage     (tick.volt),
        .button_event        (tick.button),
        .now_ms              (tick.now),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .usb_role            (usb_role),
        .port_status         (port_status),
        .boost_level         (boost_level),
        .boost_output_mw     (boost_output_mw),
        .otg_enable          (otg_enable),
        .alt_charger_disable (alt_charger_disable),
        .negotiator_mode     (negotiator_mode),
        .cc_source           (cc_source),
        .alt_reset_pulse     (alt_reset_pulse),
        .overdraw_fault      (overdraw_fault),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // Pack the result ports in the field order of the result struct.
    assign report = {usb_role, port_status, boost_level, boost_output_mw, otg_enable,
                     alt_charger_disable, negotiator_mode, cc_source, alt_reset_pulse,
                     overdraw_fault};

    usb_power_role_boost_controller_checker role_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .tick            (tick),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .report          (report),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .reports_pending (reports_pending),
        .failures        (failures),
        .shutoffs        (shutoffs)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result side: stall about one cycle in ten, except in the calm stretch.
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 10);
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("usb_power_role_boost_controller_top_tb failed");
        $finish;
    end

    function automatic item_t tick_of(input logic vbus, input logic chg,
                                      input logic [6:0] pct, input int cur,
                                      input int cur_avg, input int volt,
                                      input logic button, input logic [31:0] now);
        item_t t;
        t.vbus    = vbus;
        t.chg     = chg;
        t.pct     = pct;
        t.cur     = 16'(cur);
        t.cur_avg = 16'(cur_avg);
        t.volt    = 16'(volt);
        t.button  = button;
        t.now     = now;
        return t;
    endfunction

    // Write one register and drop valid for a cycle; track in-range writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IDLE_DRAW:  knobs.idle_draw  = val;
            CFG_MAX_DRAW:   knobs.max_draw   = val;
            CFG_BOOST_GAP:  knobs.boost_gap  = val;
            CFG_OVER_DELAY: knobs.over_delay = val;
            CFG_RAISE_INT:  knobs.raise_int  = val;
            default:        ;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] idle, input logic [15:0] max_draw,
                              input logic [15:0] gap, input logic [15:0] over_delay,
                              input logic [15:0] raise_int);
        write_reg(CFG_IDLE_DRAW, idle);
        write_reg(CFG_MAX_DRAW, max_draw);
        write_reg(CFG_BOOST_GAP, gap);
        write_reg(CFG_OVER_DELAY, over_delay);
        write_reg(CFG_RAISE_INT, raise_int);
        settings_used++;
    endtask

    // Present one tick and hold it until the block takes it. Valid stays
    // high into the next tick unless an idle cycle is drawn first.
    task automatic send_tick(input item_t t);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        tick     <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0)
            @(posedge clk);
    endtask

    // Random traffic as episodes: a steady supply picture and one draw band
    // held for a stretch, so boost level ramps, step-downs and overdraw
    // timeouts get a chance to play out. About one tick in ten is noise.
    task automatic run_traffic(input int count);
        item_t t;
        int    left;
        int    span;
        int    band;
        int    chg_mode;
        int    i;
        int    f;
        int    lo;
        int    hi;
        int    mag;
        logic  steady_vbus;
        left = count;
        while (left > 0)
        begin
            span = $urandom_range(6, 40);
            if (span > left)
                span = left;
            band        = $urandom_range(0, 9);
            chg_mode    = $urandom_range(0, 9);
            steady_vbus = ($urandom_range(0, 9) < 8);
            // jump close to the 32-bit wrap now and then
            if ($urandom_range(0, 11) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            for (i = 0; i < span; i++)
            begin
                clock_ms = clock_ms + $urandom_range(0, 160);
                if ($urandom_range(0, 9) == 0)
                begin
                    t = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
                end
                else
                begin
                    t.vbus = ($urandom_range(0, 19) == 0) ? !steady_vbus : steady_vbus;
                    if (chg_mode < 6)
                        t.chg = 1'b0;
                    else if (chg_mode < 8)
                        t.chg = 1'b1;
                    else
                        t.chg = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 19))
                        0:       t.pct = PCT_FULL;
                        1:       t.pct = 7'($urandom_range(101, 127));
                        2:       t.pct = '0;
                        default: t.pct = 7'($urandom_range(1, 99));
                    endcase
                    t.button = (i == 0) ? 1'($urandom_range(0, 1))
                                        : ($urandom_range(0, 29) == 0);
                    t.volt = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(3000, 4400));
                    // aim the fast power at under, inside or over the window
                    lo = int'(knobs.idle_draw) + 1;
                    hi = int'(knobs.max_draw) - int'(knobs.boost_gap) - 1;
                    if (band < 3)
                        f = $urandom_range(0, knobs.idle_draw);
                    else if (band < 7 && hi >= lo)
                        f = $urandom_range(lo, hi);
                    else if (band < 7)
                        f = $urandom_range(0, 70000);
                    else
                        f = int'(knobs.max_draw) + 1 + $urandom_range(0, 40000);
                    if (t.volt == '0 || $urandom_range(0, 9) == 0)
                        mag = $urandom_range(0, 32768);
                    else
                        mag = (f * 100 + int'(t.volt) - 1) / int'(t.volt);
                    if (mag > 32768)
                        mag = 32768;
                    if ($urandom_range(0, 1))
                        t.cur = 16'(-mag);
                    else
                        t.cur = 16'((mag > 32767) ? 32767 : mag);
                    if ($urandom_range(0, 9) < 7)
                        t.cur_avg = t.cur + 16'($urandom_range(0, 64)) - 16'd32;
                    else
                        t.cur_avg = 16'($urandom);
                    t.now = clock_ms;
                end
                send_tick(t);
            end
            left -= span;
        end
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        tick      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        knobs         = '{IDLE_DRAW_RST, MAX_DRAW_RST, BOOST_GAP_RST,
                          OVER_DELAY_RST, RAISE_INT_RST};
        clock_ms      = '0;
        ticks_sent    = 0;
        settings_used = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the roles at the reset limits.
        // Client: everything zero, then charging with a discharging battery
        // and a percent above 100 (not full, so the alt charger reset pulses),
        // then full, then charge port present with all field extremes.
        send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(1, 0, 101, -1000, -1000, NOMINAL_VOLT, 0, 10));
        send_tick(tick_of(1, 0, PCT_FULL, -32768, 32767, 0, 0, 20));
        send_tick(tick_of(1, 1, 127, 32767, -32768, FULL_VOLT, 0, 30));
        send_tick(tick_of(0, 0, 50, 0, 0, NOMINAL_VOLT, 0, 40));
        // Button into boost under heavy draw just short of the wrap: now plus
        // the delay lands on zero, which already lies before now, so the block
        // faults straight back to client and the deadline stays unarmed. The
        // next tick has no button and stays in client.
        send_tick(tick_of(0, 0, 50, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 1, 32'hFFFF_FE0C));
        send_tick(tick_of(0, 0, 50, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 0, 32'hFFFF_FFF0));
        // Back into boost under overdraw at a low time: arm a fresh deadline.
        send_tick(tick_of(0, 0, 50, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 1, 1000));
        // Pass-through in and out by button, then lose the charge port into boost.
        send_tick(tick_of(1, 1, 60, 0, 0, NOMINAL_VOLT, 1, 1100));
        send_tick(tick_of(1, 1, 60, 0, 0, NOMINAL_VOLT, 1, 1200));
        send_tick(tick_of(1, 1, 60, 0, 0, NOMINAL_VOLT, 1, 1300));
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 0, 1400));
        // Boost regulation: raise, rate limit, raise again, step down on
        // under- and over-draw, then overdraw held at level 0 until it faults.
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 0, 1500));
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 0, 1550));
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 0, 1601));
        send_tick(tick_of(1, 0, 60, LIGHT_CUR, LIGHT_CUR, NOMINAL_VOLT, 0, 1700));
        send_tick(tick_of(1, 0, 60, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 0, 1800));
        send_tick(tick_of(1, 0, 60, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 0, 1900));
        send_tick(tick_of(1, 0, 60, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 0, 2400));
        send_tick(tick_of(1, 0, 60, HEAVY_CUR, HEAVY_CUR, FULL_VOLT, 0, 2401));
        // Button into boost, button back out, into boost again, charge port to pass.
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 1, 2500));
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 1, 2600));
        send_tick(tick_of(1, 0, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 1, 2700));
        send_tick(tick_of(1, 1, 60, WINDOW_CUR, WINDOW_CUR, NOMINAL_VOLT, 0, 2800));
        // All-ones corner with a button press while in pass-through.
        send_tick(tick_of(1, 1, 127, -1, -1, FULL_VOLT, 1, 32'hFFFF_FFFF));
        clock_ms = 32'd3000;
        run_traffic(130);
        settle();

        // Widest window, no delays, no rate limit; no idling on either side.
        set_limits(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        calm = 1'b1;
        run_traffic(150);
        calm = 1'b0;
        settle();

        // Everything but the max at the top: the gap exceeds the max, so the window is
        // empty. Also poke the unused register indexes, which must be dropped.
        set_limits(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_RAISE_INT + 3'd1, 16'($urandom));
        write_reg(CFG_RAISE_INT + 3'd2, 16'($urandom));
        write_reg(CFG_RAISE_INT + 3'd3, 16'($urandom));
        run_traffic(120);
        settle();

        // Realistic spreads of the limits.
        repeat (4)
        begin
            set_limits(16'($urandom_range(200, 1500)), 16'($urandom_range(2000, 12000)),
                       16'($urandom_range(0, 3000)), 16'($urandom_range(0, 800)),
                       16'($urandom_range(0, 300)));
            write_reg(CFG_RAISE_INT + 3'($urandom_range(1, 3)), 16'($urandom));
            run_traffic(160);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d ticks over %0d register settings: directed role walk, then",
                 ticks_sent, settings_used);
        $display("episodes of under, window and over draw; %0d overdraw shut-offs predicted.",
                 shutoffs);
        if (failures == 0)
            $display("usb_power_role_boost_controller_top_tb passed");
        else
            $display("usb_power_role_boost_controller_top_tb failed");
        $finish;
    end

endmodule
